// ===== sv/mse_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types of the merge sort engine
package mse_pkg;

	localparam int DATA_W       = 32;
	localparam int CAPACITY_DEF = 64;

	typedef struct packed {
		logic done;
		logic src;
	} mse_stat_t;

endpackage

// ===== sv/mse_merge.sv =====
`timescale 1ns / 1ps
// bottom-up merge pass sequencer with compare and select datapath
module mse_merge #(
	parameter int CAPACITY = mse_pkg::CAPACITY_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [$clog2(CAPACITY+1)-1:0]         n_in,
	input  logic signed [mse_pkg::DATA_W-1:0]     ra,
	input  logic signed [mse_pkg::DATA_W-1:0]     rb,
	output logic [$clog2(CAPACITY)-1:0]           rd_a_addr,
	output logic [$clog2(CAPACITY)-1:0]           rd_b_addr,
	output logic                                  wr_en,
	output logic [$clog2(CAPACITY)-1:0]           wr_addr,
	output logic signed [mse_pkg::DATA_W-1:0]     wr_data,
	output mse_pkg::mse_stat_t                    stat
);
	import mse_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int PW    = CNT_W + 2;

	localparam logic [1:0] M_IDLE  = 2'd0;
	localparam logic [1:0] M_SETUP = 2'd1;
	localparam logic [1:0] M_RUN   = 2'd2;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] n_q, mid_q, hi_q, a_q, b_q, k_q;
	logic [PW-1:0]    w_q, lo_q;
	logic             src_q, done_q;

	logic [PW-1:0]    n_ext, lo_w, lo_2w, w2;
	logic [CNT_W-1:0] mid_c, hi_c, a_n, b_n, k_n;
	logic             a_live, b_live, take_a, pair_end, pass_end, last_pass;

	always_comb begin
		n_ext     = PW'(n_q);
		lo_w      = lo_q + w_q;
		w2        = w_q << 1;
		lo_2w     = lo_q + w2;
		mid_c     = (lo_w >= n_ext) ? n_q : lo_w[CNT_W-1:0];
		hi_c      = (lo_2w >= n_ext) ? n_q : lo_2w[CNT_W-1:0];
		a_live    = a_q != mid_q;
		b_live    = b_q != hi_q;
		take_a    = a_live && (!b_live || (ra < rb));
		a_n       = a_q + CNT_W'(take_a);
		b_n       = b_q + CNT_W'(!take_a);
		k_n       = k_q + CNT_W'(1);
		pair_end  = k_n == hi_q;
		pass_end  = lo_2w >= n_ext;
		last_pass = w2 >= n_ext;
	end

	always_comb begin
		unique case (state_q)
			M_SETUP: begin
				rd_a_addr = lo_q[IDX_W-1:0];
				rd_b_addr = mid_c[IDX_W-1:0];
			end
			M_RUN: begin
				rd_a_addr = a_n[IDX_W-1:0];
				rd_b_addr = b_n[IDX_W-1:0];
			end
			default: begin
				rd_a_addr = '0;
				rd_b_addr = '0;
			end
		endcase
	end

	assign wr_en      = state_q == M_RUN;
	assign wr_addr    = k_q[IDX_W-1:0];
	assign wr_data    = take_a ? ra : rb;
	assign stat.done  = done_q;
	assign stat.src   = src_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
			src_q   <= 1'b0;
			n_q     <= '0;
			w_q     <= '0;
			lo_q    <= '0;
			mid_q   <= '0;
			hi_q    <= '0;
			a_q     <= '0;
			b_q     <= '0;
			k_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				M_IDLE: begin
					if (start) begin
						n_q   <= n_in;
						w_q   <= PW'(1);
						lo_q  <= '0;
						src_q <= 1'b0;
						if (n_in <= CNT_W'(1)) begin
							done_q <= 1'b1;
						end else begin
							state_q <= M_SETUP;
						end
					end
				end
				M_SETUP: begin
					mid_q   <= mid_c;
					hi_q    <= hi_c;
					a_q     <= lo_q[CNT_W-1:0];
					b_q     <= mid_c;
					k_q     <= lo_q[CNT_W-1:0];
					state_q <= M_RUN;
				end
				M_RUN: begin
					a_q <= a_n;
					b_q <= b_n;
					k_q <= k_n;
					if (pair_end) begin
						if (pass_end) begin
							src_q <= ~src_q;
							lo_q  <= '0;
							w_q   <= w2;
							if (last_pass) begin
								done_q  <= 1'b1;
								state_q <= M_IDLE;
							end else begin
								state_q <= M_SETUP;
							end
						end else begin
							lo_q    <= lo_2w;
							state_q <= M_SETUP;
						end
					end
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/merge_sort_engine.sv =====
`timescale 1ns / 1ps
// top level of the merge sort engine: element memories, load and result sequencing
//
// Loads one signed 32-bit element per cycle into memory A of a ping-pong pair
// of memories until the element marked final; elements beyond CAPACITY are
// dropped and flag overflow on every result of that set. The n stored elements
// are then sorted ascending by ceil(log2(n)) bottom-up merge passes. In the run
// state one element is merged per cycle, after a setup state per pair of runs,
// through the two read ports of the source memory. Each result is read in a
// fetch state and offered in a show state, the next not fetched until it is
// accepted, with last_result on the final one; the block takes the next set
// after the final result is accepted. Input is not accepted while a set is
// being sorted or emitted. No clearing pass follows reset.
module merge_sort_engine #(
	parameter int CAPACITY = mse_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [mse_pkg::DATA_W-1:0] element,
	input  logic                              final_element,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [mse_pkg::DATA_W-1:0] sorted_value,
	output logic                              last_result,
	output logic                              overflow
);
	import mse_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	localparam logic [1:0] S_LOAD  = 2'd0;
	localparam logic [1:0] S_SORT  = 2'd1;
	localparam logic [1:0] S_FETCH = 2'd2;
	localparam logic [1:0] S_SHOW  = 2'd3;

	logic [1:0]       state_q;
	logic [CNT_W-1:0] count_q, e_q, cnt_n;
	logic             ovf_q, sel_q;

	logic signed [DATA_W-1:0] mem_a_q [CAPACITY];
	logic signed [DATA_W-1:0] mem_b_q [CAPACITY];
	logic signed [DATA_W-1:0] a0_q, a1_q, b0_q, b1_q;

	logic                     in_acc, out_acc, room, m_start;
	logic [IDX_W-1:0]         rda, m_rd_a, m_rd_b, m_wr_addr;
	logic                     m_wr_en;
	logic signed [DATA_W-1:0] m_ra, m_rb, m_wr_data;
	mse_stat_t                m_stat;

	assign in_ready     = state_q == S_LOAD;
	assign in_acc       = in_valid && in_ready;
	assign out_valid    = state_q == S_SHOW;
	assign out_acc      = out_valid && out_ready;
	assign room         = count_q != CNT_W'(CAPACITY);
	assign cnt_n        = count_q + CNT_W'(room);
	assign m_start      = in_acc && final_element;
	assign rda          = (state_q == S_SORT) ? m_rd_a : e_q[IDX_W-1:0];
	assign m_ra         = m_stat.src ? b0_q : a0_q;
	assign m_rb         = m_stat.src ? b1_q : a1_q;
	assign sorted_value = sel_q ? b0_q : a0_q;
	assign last_result  = (e_q + CNT_W'(1)) == count_q;
	assign overflow     = ovf_q;

	mse_merge #(
		.CAPACITY(CAPACITY)
	) u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (m_start),
		.n_in     (cnt_n),
		.ra       (m_ra),
		.rb       (m_rb),
		.rd_a_addr(m_rd_a),
		.rd_b_addr(m_rd_b),
		.wr_en    (m_wr_en),
		.wr_addr  (m_wr_addr),
		.wr_data  (m_wr_data),
		.stat     (m_stat)
	);

	// ping-pong element memories
	always_ff @(posedge clk) begin
		if (in_acc && room) begin
			mem_a_q[count_q[IDX_W-1:0]] <= element;
		end else if (m_wr_en && m_stat.src) begin
			mem_a_q[m_wr_addr] <= m_wr_data;
		end
		if (m_wr_en && !m_stat.src) begin
			mem_b_q[m_wr_addr] <= m_wr_data;
		end
		a0_q <= mem_a_q[rda];
		a1_q <= mem_a_q[m_rd_b];
		b0_q <= mem_b_q[rda];
		b1_q <= mem_b_q[m_rd_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
			sel_q   <= 1'b0;
			e_q     <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (room) begin
							count_q <= cnt_n;
						end else begin
							ovf_q <= 1'b1;
						end
						if (final_element) begin
							state_q <= S_SORT;
						end
					end
				end
				S_SORT: begin
					if (m_stat.done) begin
						sel_q   <= m_stat.src;
						e_q     <= '0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_SHOW;
				end
				S_SHOW: begin
					if (out_acc) begin
						if (last_result) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							e_q     <= e_q + CNT_W'(1);
							state_q <= S_FETCH;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the merge sort engine: directed table, random sets, sort predictor
module testbench;

	import mse_pkg::*;

	localparam int SET_CAPACITY = CAPACITY_DEF;
	localparam int RANDOM_ITEMS = 330;
	localparam int STALL_LIMIT  = 5000;
	localparam int SETTLE_CYCLES = 20;
	localparam int DIRECTED_COUNT = 18;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     last;
		logic                     ovf;
	} sorted_result_t;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic              fin;
		logic [7:0]        reps;
		logic              typed;
	} stim_row_t;

	// reps sends value, value-1, ... with fin on the last one only
	localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{32'h0000_0000, 1'b1, 8'd1,  1'b1},
		'{32'h7fff_ffff, 1'b1, 8'd1,  1'b1},
		'{32'h8000_0000, 1'b1, 8'd1,  1'b1},
		'{32'hffff_ffff, 1'b1, 8'd1,  1'b1},
		'{32'h7fff_ffff, 1'b0, 8'd1,  1'b0},
		'{32'h8000_0000, 1'b0, 8'd1,  1'b0},
		'{32'h0000_0000, 1'b0, 8'd1,  1'b0},
		'{32'hffff_ffff, 1'b0, 8'd1,  1'b0},
		'{32'h0000_0001, 1'b1, 8'd1,  1'b0},
		'{32'h0000_0005, 1'b0, 8'd1,  1'b0},
		'{32'h0000_0005, 1'b0, 8'd1,  1'b0},
		'{32'hffff_fffd, 1'b0, 8'd1,  1'b0},
		'{32'h0000_0005, 1'b1, 8'd1,  1'b0},
		'{32'h0000_0003, 1'b0, 8'd3,  1'b0},
		'{32'h0000_0000, 1'b1, 8'd1,  1'b0},
		'{32'h0000_03e8, 1'b1, 8'd64, 1'b0},
		'{32'hffff_ff9c, 1'b0, 8'd66, 1'b0},
		'{32'h7fff_ffff, 1'b1, 8'd1,  1'b0}
	};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [DATA_W-1:0] element = '0;
	logic                     final_element = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] sorted_value;
	logic                     last_result;
	logic                     overflow;

	idle_mode_t               idle_mode = IDLE_NONE;
	sorted_result_t           sorted_expect [$];
	int                       mismatch_count = 0;
	int                       stall_cycles = 0;

	logic signed [DATA_W-1:0] held_values [SET_CAPACITY];
	logic signed [DATA_W-1:0] merge_buf [SET_CAPACITY];
	logic [6:0]               held_count = '0;
	logic                     held_overflow = 1'b0;

	merge_sort_engine #(.CAPACITY(SET_CAPACITY)) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.element      (element),
		.final_element(final_element),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.sorted_value (sorted_value),
		.last_result  (last_result),
		.overflow     (overflow)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int sender_idle_pct(idle_mode_t mode);
		return (mode == IDLE_SENDER) ? 66 : (mode == IDLE_BOTH) ? 10 : 0;
	endfunction

	function automatic int receiver_stall_pct(idle_mode_t mode);
		return (mode == IDLE_RECEIVER) ? 66 : (mode == IDLE_BOTH) ? 10 : 0;
	endfunction

	// on a tie the right-hand element goes first
	function automatic void merge_span(int lo, int mid, int hi);
		int a;
		int b;
		int k;
		a = lo;
		b = mid + 1;
		k = 0;
		while (a <= mid && b <= hi) begin
			if (held_values[a] < held_values[b]) begin
				merge_buf[k] = held_values[a];
				a++;
			end else begin
				merge_buf[k] = held_values[b];
				b++;
			end
			k++;
		end
		while (a <= mid) begin
			merge_buf[k] = held_values[a];
			a++;
			k++;
		end
		while (b <= hi) begin
			merge_buf[k] = held_values[b];
			b++;
			k++;
		end
		for (int i = 0; i < k; i++)
			held_values[lo + i] = merge_buf[i];
	endfunction

	function automatic void sort_span(int lo, int hi);
		int mid;
		if (lo >= hi)
			return;
		mid = lo + (hi - lo) / 2;
		sort_span(lo, mid);
		sort_span(mid + 1, hi);
		merge_span(lo, mid, hi);
	endfunction

	function automatic void predict_element(logic [DATA_W-1:0] value, logic fin, bit push);
		sorted_result_t r;
		if (held_count < SET_CAPACITY) begin
			held_values[held_count] = value;
			held_count++;
		end else begin
			held_overflow = 1'b1;
		end
		if (fin) begin
			if (held_count > 0)
				sort_span(0, held_count - 1);
			for (int k = 0; k < held_count; k++) begin
				r.value = held_values[k];
				r.last  = (k == held_count - 1);
				r.ovf   = held_overflow;
				if (push)
					sorted_expect.push_back(r);
			end
			held_count    = '0;
			held_overflow = 1'b0;
		end
	endfunction

	task automatic note_mismatch(string what);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch at %0t: %s", $realtime, what);
	endtask

	// returns at the edge that accepts the transaction
	task automatic send_element(logic [DATA_W-1:0] value, logic fin);
		int gap_pct;
		gap_pct = sender_idle_pct(idle_mode);
		if ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < gap_pct);
		end
		in_valid      <= 1'b1;
		element       <= value;
		final_element <= fin;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sorted_expect.size() != 0);
	endtask

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_stall_pct(idle_mode));
	end

	always @(posedge clk) begin
		sorted_result_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			if (sorted_expect.size() == 0) begin
				note_mismatch($sformatf("unexpected transaction value=%0d last=%0b ovf=%0b",
					sorted_value, last_result, overflow));
			end else begin
				exp_r = sorted_expect.pop_front();
				if (sorted_value !== exp_r.value || last_result !== exp_r.last ||
					overflow !== exp_r.ovf)
					note_mismatch($sformatf(
						"expected value=%0d last=%0b ovf=%0b, got value=%0d last=%0b ovf=%0b",
						exp_r.value, exp_r.last, exp_r.ovf,
						sorted_value, last_result, overflow));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("merge_sort_engine verification failed");
			$finish;
		end
	end

	initial begin
		stim_row_t         row;
		logic [DATA_W-1:0] value;
		logic              fin;
		sorted_result_t    single;
		int                random_sent;
		int                set_size;
		int                size_pick;
		idle_mode_t        next_mode;

		random_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			row = DIRECTED_ROWS[i];
			for (int rep = 0; rep < row.reps; rep++) begin
				value = row.value - rep;
				fin   = row.fin && (rep == row.reps - 1);
				send_element(value, fin);
				predict_element(value, fin, !row.typed);
				if (row.typed) begin
					single.value = value;
					single.last  = 1'b1;
					single.ovf   = 1'b0;
					sorted_expect.push_back(single);
				end
			end
		end
		wait_for_results();

		while (random_sent < RANDOM_ITEMS) begin
			next_mode = idle_mode_t'(random_sent * 4 / RANDOM_ITEMS);
			if (next_mode != idle_mode) begin
				wait_for_results();
				idle_mode = next_mode;
			end
			size_pick = $urandom_range(99);
			if (size_pick < 70)
				set_size = $urandom_range(12, 1);
			else if (size_pick < 90)
				set_size = $urandom_range(40, 13);
			else if (size_pick < 96)
				set_size = $urandom_range(SET_CAPACITY, 41);
			else
				set_size = $urandom_range(SET_CAPACITY + 6, SET_CAPACITY + 1);
			for (int k = 0; k < set_size; k++) begin
				case ($urandom_range(3))
					0, 1: value = $urandom;
					2: value = $urandom_range(7) - 4;
					default: value = $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
						: 32'h8000_0000 + $urandom_range(3);
				endcase
				fin = (k == set_size - 1);
				send_element(value, fin);
				predict_element(value, fin, 1'b1);
				random_sent++;
			end
			if ($urandom_range(7) == 0)
				wait_for_results();
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("merge_sort_engine verification clean");
		else
			$display("merge_sort_engine verification failed");
		$finish;
	end

endmodule
